// ===== rtl/bffa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the allocator.
`default_nettype none
package bffa_pkg;

    // pool geometry
    localparam int NUM_CHUNKS   = 32768;
    localparam int CHUNK_BYTES  = 32;
    localparam int HEADER_BYTES = 16;

    localparam int CHUNK_W   = $clog2(NUM_CHUNKS);
    localparam int CSH       = $clog2(CHUNK_BYTES);
    localparam int LEN_W     = $clog2(NUM_CHUNKS) + 1;
    localparam int MAP_W     = 8;
    localparam int MAP_SH    = $clog2(MAP_W);
    localparam int MAP_DEPTH = NUM_CHUNKS / MAP_W;
    localparam int MAP_AW    = CHUNK_W - MAP_SH;

    // field widths
    localparam int ADDR_W = 32;
    localparam int REQ_W  = 21;
    localparam int FREE_W = 21;
    localparam int SIZE_W = REQ_W + 1;

    localparam logic [FREE_W-1:0] POOL_BYTES = FREE_W'(NUM_CHUNKS * CHUNK_BYTES);
    localparam logic [ADDR_W-1:0] POOL_SPAN  = ADDR_W'(NUM_CHUNKS * CHUNK_BYTES);
    localparam logic [ADDR_W-1:0] RESET_BASE = 32'h0030_0000;

    // request and status codes
    localparam logic       REQ_ALLOC  = 1'b0;
    localparam logic       REQ_FREE   = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NORUN   = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       scan_start;
        logic       scan;
        logic       mark_init;
        logic       mark_rd;
        logic       mark_wr;
        logic       fin;
        logic       commit;
        logic [1:0] fin_status;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic too_few;
        logic need_zero;
        logic found;
        logic nofit;
        logic addr_zero;
        logic addr_bad;
        logic len_zero;
        logic mark_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/bffa_dp.sv =====
// Allocator datapath: bitmap and run-length memories, scan, marking and free count.
`default_nettype none
module bffa_dp import bffa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_data,
    input  wire logic              i_req_type,
    input  wire logic [REQ_W-1:0]  i_request_bytes,
    input  wire logic [ADDR_W-1:0] i_free_address,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [ADDR_W-1:0]      o_data_address,
    output logic [FREE_W-1:0]      o_free_bytes
);

    logic [MAP_W-1:0] mem_map [MAP_DEPTH];
    logic [LEN_W-1:0] mem_run [NUM_CHUNKS];

    logic [ADDR_W-1:0]  r_base;
    logic [FREE_W-1:0]  r_free;
    logic               r_type;
    logic [REQ_W-1:0]   r_req;
    logic [ADDR_W-1:0]  r_in_addr;
    logic [LEN_W-1:0]   r_need;
    logic [CHUNK_W-1:0] r_clr;
    logic [MAP_AW-1:0]  r_rd_addr;
    logic               r_rd_last;
    logic               r_q_valid;
    logic [MAP_AW-1:0]  r_q_idx;
    logic [LEN_W-1:0]   r_run;
    logic [CHUNK_W-1:0] r_first;
    logic               r_found;
    logic               r_nofit;
    logic [CHUNK_W-1:0] r_p;
    logic [LEN_W-1:0]   r_left;
    logic [MAP_W-1:0]   r_map_q;
    logic [LEN_W-1:0]   r_len_q;
    logic               r_done;
    logic [1:0]         r_status;
    logic [ADDR_W-1:0]  r_data_addr;

    logic [SIZE_W-1:0]  alloc_bytes;
    logic [SIZE_W:0]    need_full;
    logic [ADDR_W-1:0]  off;
    logic [CHUNK_W-1:0] off_start;
    logic [LEN_W-1:0]   v_run;
    logic [CHUNK_W-1:0] v_first;
    logic               v_found;
    logic               issue;
    logic               process_q;
    logic [MAP_SH-1:0]  bo;
    logic [MAP_SH:0]    avail;
    logic [MAP_SH:0]    n_step;
    logic               step_last;
    logic [MAP_W-1:0]   mask;
    logic               map_we;
    logic [MAP_AW-1:0]  map_wa;
    logic [MAP_W-1:0]   map_wd;
    logic [MAP_AW-1:0]  map_ra;
    logic               run_we;
    logic [CHUNK_W-1:0] run_wa;
    logic [LEN_W-1:0]   run_wd;
    logic [FREE_W-1:0]  n_free;
    logic [ADDR_W-1:0]  n_data_addr;

    // size of the request plus its header in whole chunks
    assign alloc_bytes = SIZE_W'(r_req) + SIZE_W'(HEADER_BYTES);
    assign need_full = ({1'b0, alloc_bytes} + (SIZE_W+1)'(CHUNK_BYTES - 1)) >> CSH;

    // offset of a freed address from the pool start
    assign off       = r_in_addr - ADDR_W'(HEADER_BYTES) - r_base;
    assign off_start = off[CSH+CHUNK_W-1:CSH];

    // walk one bitmap word, tracking the current free run
    always_comb begin
        v_run   = r_run;
        v_first = r_first;
        v_found = 1'b0;
        for (int b = 0; b < MAP_W; b++) begin
            if (!v_found) begin
                if (r_map_q[b]) begin
                    v_run = '0;
                end else begin
                    if (v_run == '0) begin
                        v_first = {r_q_idx, MAP_SH'(b)};
                    end
                    v_run = v_run + 1'b1;
                    if (v_run == r_need) begin
                        v_found = 1'b1;
                    end
                end
            end
        end
    end

    assign issue     = i_cmd.scan && !r_found && !r_nofit && !r_rd_last;
    assign process_q = i_cmd.scan && r_q_valid && !r_found && !r_nofit;

    // bits of the current word covered by the run being marked
    assign bo        = r_p[MAP_SH-1:0];
    assign avail     = (MAP_SH+1)'(MAP_W) - {1'b0, bo};
    assign step_last = r_left <= LEN_W'(avail);
    assign n_step    = step_last ? r_left[MAP_SH:0] : avail;

    always_comb begin
        for (int j = 0; j < MAP_W; j++) begin
            mask[j] = ((MAP_SH+2)'(j) >= (MAP_SH+2)'(bo)) &&
                      ((MAP_SH+2)'(j) < (MAP_SH+2)'(bo) + (MAP_SH+2)'(n_step));
        end
    end

    // memory port selection
    assign map_ra = i_cmd.mark_rd ? r_p[CHUNK_W-1:MAP_SH] : r_rd_addr;
    always_comb begin
        map_we = i_cmd.clr || i_cmd.mark_wr;
        map_wa = i_cmd.clr ? r_clr[CHUNK_W-1:MAP_SH] : r_p[CHUNK_W-1:MAP_SH];
        if (i_cmd.clr) begin
            map_wd = '0;
        end else if (r_type == REQ_FREE) begin
            map_wd = r_map_q & ~mask;
        end else begin
            map_wd = r_map_q | mask;
        end
    end

    always_comb begin
        run_we = i_cmd.clr || (i_cmd.fin && i_cmd.commit);
        if (i_cmd.clr) begin
            run_wa = r_clr;
            run_wd = '0;
        end else if (r_type == REQ_FREE) begin
            run_wa = off_start;
            run_wd = '0;
        end else begin
            run_wa = r_first;
            run_wd = r_need;
        end
    end

    // free count and returned address on completion
    always_comb begin
        n_free      = r_free;
        n_data_addr = '0;
        if (i_cmd.fin && i_cmd.commit) begin
            if (r_type == REQ_FREE) begin
                n_free = r_free + FREE_W'({r_len_q, {CSH{1'b0}}});
            end else begin
                n_free      = r_free - FREE_W'({r_need, {CSH{1'b0}}});
                n_data_addr = r_base + ADDR_W'({r_first, {CSH{1'b0}}})
                              + ADDR_W'(HEADER_BYTES);
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        r_map_q <= mem_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (run_we) begin
            mem_run[run_wa] <= run_wd;
        end
        r_len_q <= mem_run[off_start];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= RESET_BASE;
            r_free    <= POOL_BYTES;
            r_clr     <= '0;
            r_done    <= 1'b0;
            r_found   <= 1'b0;
            r_nofit   <= 1'b0;
            r_q_valid <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            r_free <= n_free;
            r_done <= i_cmd.fin;
            if (i_cmd.scan_start) begin
                r_found   <= 1'b0;
                r_nofit   <= 1'b0;
                r_q_valid <= 1'b0;
                r_rd_last <= 1'b0;
            end else begin
                r_q_valid <= issue;
                if (issue && r_rd_addr == '1) begin
                    r_rd_last <= 1'b1;
                end
                if (process_q) begin
                    if (v_found) begin
                        r_found <= 1'b1;
                    end else if (r_q_idx == '1) begin
                        r_nofit <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type    <= i_req_type;
            r_req     <= i_request_bytes;
            r_in_addr <= i_free_address;
        end
        if (i_cmd.scan_start) begin
            r_need    <= LEN_W'(need_full);
            r_rd_addr <= '0;
            r_run     <= '0;
        end else begin
            if (issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            r_q_idx <= r_rd_addr;
            if (process_q) begin
                r_run   <= v_run;
                r_first <= v_first;
            end
        end
        if (i_cmd.mark_init) begin
            if (r_type == REQ_FREE) begin
                r_p    <= off_start;
                r_left <= r_len_q;
            end else begin
                r_p    <= r_first;
                r_left <= r_need;
            end
        end else if (i_cmd.mark_wr) begin
            r_p    <= r_p + CHUNK_W'(n_step);
            r_left <= r_left - LEN_W'(n_step);
        end
        if (i_cmd.fin) begin
            r_status    <= i_cmd.fin_status;
            r_data_addr <= n_data_addr;
        end
    end

    // status towards the controller
    assign o_sts.clr_done  = r_clr == '1;
    assign o_sts.is_free   = r_type == REQ_FREE;
    assign o_sts.too_few   = SIZE_W'(r_free) < alloc_bytes;
    assign o_sts.need_zero = need_full == '0;
    assign o_sts.found     = r_found;
    assign o_sts.nofit     = r_nofit;
    assign o_sts.addr_zero = r_in_addr == '0;
    assign o_sts.addr_bad  = (off >= POOL_SPAN) || (off[CSH-1:0] != '0);
    assign o_sts.len_zero  = r_len_q == '0;
    assign o_sts.mark_last = step_last;

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_data_address = r_data_addr;
    assign o_free_bytes   = r_free;

endmodule
`default_nettype wire

// ===== rtl/bffa_ctrl.sv =====
// Allocator controller: sequences clearing, checks, scan, marking and completion.
`default_nettype none
module bffa_ctrl import bffa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_busy
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ACHK = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_FCHK = 4'd4;
    localparam logic [3:0] S_FLEN = 4'd5;
    localparam logic [3:0] S_MRD  = 4'd6;
    localparam logic [3:0] S_MWR  = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ACHK;
                end
            end
            S_ACHK: begin
                if (i_sts.is_free) begin
                    n_state = S_FCHK;
                end else if (i_sts.too_few) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_NOSPACE;
                    n_state          = S_IDLE;
                end else if (i_sts.need_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_NORUN;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found) begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MRD;
                end else if (i_sts.nofit) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_NORUN;
                    n_state          = S_IDLE;
                end
            end
            S_FCHK: begin
                if (i_sts.addr_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end else if (i_sts.addr_bad) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_BADFREE;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_FLEN;
                end
            end
            S_FLEN: begin
                if (i_sts.len_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ST_BADFREE;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MWR;
            end
            S_MWR: begin
                o_cmd.mark_wr = 1'b1;
                if (i_sts.mark_last) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.commit     = 1'b1;
                    o_cmd.fin_status = ST_OK;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_MRD;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // hold state; reset enters the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule
`default_nettype wire

// ===== rtl/bitmap_first_fit_allocator.sv =====
// Top level of the first-fit chunk allocator: controller plus datapath.
//
// Raise start with an item while busy is low; the item is taken at that edge.
// Exactly one result follows, shown for one cycle with o_done high, and busy
// falls in that same cycle, so the receiver must take it then. After reset the
// block sweeps its memories (one run-length entry a cycle) with busy high;
// configuration writes are taken meanwhile. An allocation refused by its
// checks ends there; otherwise the bitmap is scanned one 8-chunk word per
// cycle from chunk 0, then the run is marked with a read-modify-write, a
// read state then a write state, per bitmap word it touches. A free is
// checked on its address, then on its stored run length, and if accepted its
// run is cleared the same way.
`default_nettype none
module bitmap_first_fit_allocator import bffa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [ADDR_W-1:0] i_cfg_data,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_req_type,
    input  wire logic [REQ_W-1:0]  i_request_bytes,
    input  wire logic [ADDR_W-1:0] i_free_address,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [ADDR_W-1:0]      o_data_address,
    output logic [FREE_W-1:0]      o_free_bytes
);

    t_cmd cmd;
    t_sts sts;

    bffa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bffa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_data_address  (o_data_address),
        .o_free_bytes    (o_free_bytes)
    );

endmodule
`default_nettype wire

// ===== rtl/bffa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
module bffa_checker import bffa_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_done,
    input wire logic [1:0]        o_status,
    input wire logic [ADDR_W-1:0] o_data_address,
    input wire logic [FREE_W-1:0] o_free_bytes
);

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");

    // a result marks the end of the item
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while busy");

    // one cycle per result
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result held for more than one cycle");

    // failed requests return no address
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_OK |-> o_data_address == '0)
        else $error("address returned with a failing status");

    // free count never exceeds the pool when a result is shown
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_free_bytes <= POOL_BYTES) else $error("free count above pool size");

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_data_address (o_data_address),
    .o_free_bytes   (o_free_bytes)
);
`default_nettype wire
